/* src/bdsg_pkg.sv */
// Shared types, register indexes and a constant table for the display stretch block.
`default_nettype none
package bdsg_pkg;

    localparam int IMAGE_WIDTH_W = 13;
    localparam int PIX_W         = 16;
    localparam int GRAY_W        = 8;
    localparam int SUM_W         = 18;
    localparam int DIV_W         = 50;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int ROOT_W        = 30;
    localparam int ROOT_N        = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BINNED_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA       = 3'd4;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_TAKE,
        OP_SUM,
        OP_CLASS,
        OP_DIV,
        OP_DIVEND,
        OP_NORM,
        OP_LOG,
        OP_MUL,
        OP_EXP,
        OP_SCALE,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic take_result;
        logic imm;
        logic gamma;
        logic step_last;
        logic t_zero;
        logic t_norm;
        logic y_big;
        logic out_free;
    } dp_stat_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = '0;
        bit_v = 64'd1 << 62;
        rem   = x;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^-(2^-k) in Q30, k = 0..15, by repeated square root from 0.5
    function automatic logic [ROOT_N*ROOT_W-1:0] build_roots();
        logic [ROOT_N*ROOT_W-1:0] tbl;
        logic [63:0]              r;
        tbl = '0;
        r   = 64'd1 << 29;
        for (int k = 0; k < ROOT_N; k++)
        begin
            tbl[k*ROOT_W +: ROOT_W] = r[ROOT_W-1:0];
            r = isqrt64(r << 30);
        end
        return tbl;
    endfunction

    localparam logic [ROOT_N*ROOT_W-1:0] ROOT_TABLE = build_roots();

endpackage
`default_nettype wire

/* src/bdsg_if.sv */
// Pixel and gray channel interfaces.
`default_nettype none
interface bdsg_pixel_if;
    logic                     valid;
    logic                     ready;
    logic [bdsg_pkg::PIX_W-1:0] pixel_value;
    logic                     frame_start;
    modport source (output valid, pixel_value, frame_start, input ready);
    modport sink (input valid, pixel_value, frame_start, output ready);
endinterface

interface bdsg_gray_if;
    logic                      valid;
    logic                      ready;
    logic [bdsg_pkg::GRAY_W-1:0] gray_value;
    logic                      row_end;
    modport source (output valid, gray_value, row_end, input ready);
    modport sink (input valid, gray_value, row_end, output ready);
endinterface
`default_nettype wire

/* src/bdsg_ctrl.sv */
// Sequencing state machine for the stretch datapath.
`default_nettype none
module bdsg_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bdsg_pkg::dp_stat_t stat,
    output bdsg_pkg::dp_cmd_t       cmd
);
    import bdsg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_CLASS,
        ST_DIV,
        ST_DIVEND,
        ST_NORM,
        ST_LOG,
        ST_MUL,
        ST_EXP,
        ST_SCALE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_TAKE;
                    state_next = stat.take_result ? ST_SUM : ST_IDLE;
                end
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                cmd.op     = OP_CLASS;
                state_next = stat.imm ? ST_EMIT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (stat.step_last)
                    state_next = ST_DIVEND;
            end
            ST_DIVEND:
            begin
                cmd.op     = OP_DIVEND;
                state_next = (!stat.gamma || stat.t_zero) ? ST_EMIT : ST_NORM;
            end
            ST_NORM:
            begin
                cmd.op = OP_NORM;
                if (stat.t_norm)
                    state_next = ST_LOG;
            end
            ST_LOG:
            begin
                cmd.op = OP_LOG;
                if (stat.step_last)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = stat.y_big ? ST_EMIT : ST_EXP;
            end
            ST_EXP:
            begin
                cmd.op = OP_EXP;
                if (stat.step_last)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* src/bdsg_dp.sv */
// Datapath: config registers, binning front end, line buffer, divider, log/exp units.
`default_nettype none
module bdsg_dp #(
    parameter int MAX_WIDTH       = 4096,
    parameter int GAMMA_FRAC_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bdsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bdsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [bdsg_pkg::PIX_W-1:0]         pixel_value,
    input  wire logic                               frame_start,
    input  wire bdsg_pkg::dp_cmd_t                  cmd,
    output bdsg_pkg::dp_stat_t                      stat,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [bdsg_pkg::GRAY_W-1:0]             gray_value,
    output logic                                    row_end
);
    import bdsg_pkg::*;

    localparam int LD    = MAX_WIDTH / 2;
    localparam int LIW   = (LD > 1) ? $clog2(LD) : 1;
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int MWW   = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (MWW > IMAGE_WIDTH_W) ? MWW : IMAGE_WIDTH_W;
    localparam logic [16:0] GAMMA_ONE = 17'(2 ** GAMMA_FRAC_BITS);
    localparam logic [5:0]  DIV_LAST  = 6'(DIV_W - 1);
    localparam logic [5:0]  ITER_LAST = 6'(ROOT_N - 1);

    // config
    logic [IMAGE_WIDTH_W-1:0] width_reg;
    logic                     binned_reg;
    logic [PIX_W-1:0]         black_reg;
    logic [PIX_W-1:0]         white_reg;
    logic [PIX_W-1:0]         gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            binned_reg <= 1'b0;
            black_reg  <= '0;
            white_reg  <= 16'hFFFF;
            gamma_reg  <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH: width_reg  <= cfg_data[IMAGE_WIDTH_W-1:0];
                REG_BINNED_MODE: binned_reg <= cfg_data[0];
                REG_BLACK_LEVEL: black_reg  <= cfg_data;
                REG_WHITE_LEVEL: white_reg  <= cfg_data;
                REG_GAMMA:       gamma_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // front end
    logic [COLW-1:0]  col_reg;
    logic             row_reg;
    logic [PIX_W-1:0] hold_reg;
    logic [COLW-1:0]  col_use;
    logic             row_use;
    logic [EW-1:0]    w_raw;
    logic [EW-1:0]    w_eff;
    logic [EW-1:0]    w_even;
    logic [EW-1:0]    col_p1;
    logic             last;
    logic             pair_end;
    logic [COLW-1:0]  idx_full;
    logic [LIW-1:0]   idx;
    logic [16:0]      pair;
    logic             take;

    assign take     = (cmd.op == OP_TAKE);
    assign col_use  = frame_start ? '0 : col_reg;
    assign row_use  = frame_start ? 1'b0 : row_reg;
    assign w_raw    = EW'(width_reg);
    assign w_eff    = (w_raw == '0) ? EW'(1)
                    : (w_raw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_raw;
    assign w_even   = {w_eff[EW-1:1], 1'b0};
    assign col_p1   = EW'(col_use) + EW'(1);
    assign last     = (col_p1 >= w_eff);
    assign pair_end = (col_p1 >= w_even);
    assign idx_full = col_use >> 1;
    assign idx      = (32'(idx_full) >= LD) ? LIW'(LD - 1) : idx_full[LIW-1:0];
    assign pair     = {1'b0, hold_reg} + {1'b0, pixel_value};

    assign stat.take_result = !binned_reg || (col_use[0] && row_use);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= 1'b0;
            hold_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= last ? '0 : col_p1[COLW-1:0];
            row_reg <= last ? ~row_use : row_use;
            if (binned_reg && !col_use[0] && !last)
                hold_reg <= pixel_value;
        end
    end

    // pair-sum line buffer
    logic [16:0] line_mem [LD];
    logic [16:0] mem_q;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (binned_reg && col_use[0] && !row_use)
                line_mem[idx] <= pair;
            mem_q <= line_mem[idx];
        end
    end

    // arithmetic
    logic [SUM_W-1:0]  s_reg;
    logic [16:0]       pair_reg;
    logic              row_end_reg;
    logic [GRAY_W-1:0] res_reg;
    logic              gamma_flag_reg;
    logic [DIV_W-1:0]  q_reg;
    logic [SUM_W-1:0]  den_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [5:0]        cnt_reg;
    logic [31:0]       t_reg;
    logic [4:0]        z_reg;
    logic [30:0]       m_reg;
    logic [15:0]       frac_reg;
    logic [2:0]        yi_reg;
    logic [15:0]       yf_reg;
    logic [30:0]       f_reg;

    // classification
    logic               lin;
    logic [25:0]        s255;
    logic signed [19:0] n_s;
    logic signed [19:0] r_s;
    logic signed [19:0] n_a;
    logic signed [19:0] r_a;
    logic               imm;
    logic [GRAY_W-1:0]  imm_val;
    logic               gamma_sel;
    logic [DIV_W-1:0]   dvd;
    logic [SUM_W-1:0]   dvs;

    always_comb
    begin
        lin  = ({1'b0, gamma_reg} == GAMMA_ONE) || (white_reg == black_reg);
        s255 = {s_reg, 8'b0} - {8'b0, s_reg};
        n_s  = $signed({2'b0, s_reg}) - $signed({2'b0, black_reg, 2'b0});
        r_s  = $signed({2'b0, white_reg, 2'b0}) - $signed({2'b0, black_reg, 2'b0});
        n_a  = (r_s < 0) ? -n_s : n_s;
        r_a  = (r_s < 0) ? -r_s : r_s;
        imm       = 1'b0;
        imm_val   = '0;
        gamma_sel = !lin;
        dvd       = DIV_W'(s255);
        dvs       = {white_reg, 2'b0};
        if (lin)
        begin
            if (white_reg == '0)
            begin
                imm     = 1'b1;
                imm_val = (s_reg == '0) ? 8'd0 : 8'd255;
            end
        end
        else
        begin
            dvd = {n_a[SUM_W-1:0], 32'b0};
            dvs = r_a[SUM_W-1:0];
            if (gamma_reg == '0)
            begin
                imm     = 1'b1;
                imm_val = 8'd255;
            end
            else if (n_a <= 0)
            begin
                imm = 1'b1;
            end
            else if (n_a >= r_a)
            begin
                imm     = 1'b1;
                imm_val = 8'd255;
            end
        end
    end

    // divider step
    logic [SUM_W:0] rem_sh;
    logic           q_bit;
    assign rem_sh = {rem_reg, q_reg[DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, den_reg});

    // log, gamma multiply, exp, scale
    logic [61:0] sq;
    logic [31:0] m2;
    logic [21:0] lval;
    logic [37:0] y_full;
    logic        y_big;
    logic [60:0] fprod;
    logic [38:0] sc;
    logic [38:0] sc_sh;

    assign sq     = m_reg * m_reg;
    assign m2     = sq[61:30];
    assign lval   = {6'(z_reg) + 6'd1, 16'b0} - {6'b0, frac_reg};
    assign y_full = lval * gamma_reg;
    assign y_big  = |(y_full >> (GAMMA_FRAC_BITS + 19));
    assign fprod  = f_reg * ROOT_TABLE[cnt_reg[3:0]*ROOT_W +: ROOT_W];
    assign sc     = {f_reg, 8'b0} - {8'b0, f_reg};
    assign sc_sh  = sc >> (30 + yi_reg);

    assign stat.imm       = imm;
    assign stat.gamma     = gamma_flag_reg;
    assign stat.step_last = (cmd.op == OP_DIV) ? (cnt_reg == DIV_LAST) : (cnt_reg == ITER_LAST);
    assign stat.t_zero    = (q_reg[31:0] == '0);
    assign stat.t_norm    = t_reg[31];
    assign stat.y_big     = y_big;
    assign stat.out_free  = !out_valid || out_ready;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_TAKE:
            begin
                s_reg       <= {pixel_value, 2'b00};
                pair_reg    <= pair;
                row_end_reg <= binned_reg ? pair_end : last;
            end
            OP_SUM:
            begin
                if (binned_reg)
                    s_reg <= {1'b0, mem_q} + {1'b0, pair_reg};
            end
            OP_CLASS:
            begin
                q_reg          <= dvd;
                den_reg        <= dvs;
                rem_reg        <= '0;
                cnt_reg        <= '0;
                gamma_flag_reg <= gamma_sel;
                res_reg        <= imm_val;
            end
            OP_DIV:
            begin
                rem_reg <= q_bit ? SUM_W'(rem_sh - {1'b0, den_reg}) : rem_sh[SUM_W-1:0];
                q_reg   <= {q_reg[DIV_W-2:0], q_bit};
                cnt_reg <= cnt_reg + 6'd1;
            end
            OP_DIVEND:
            begin
                if (!gamma_flag_reg)
                    res_reg <= (|q_reg[DIV_W-1:GRAY_W]) ? 8'd255 : q_reg[GRAY_W-1:0];
                else
                    res_reg <= '0;
                t_reg <= q_reg[31:0];
                z_reg <= '0;
            end
            OP_NORM:
            begin
                if (t_reg[31])
                begin
                    m_reg    <= t_reg[31:1];
                    cnt_reg  <= '0;
                    frac_reg <= '0;
                end
                else
                begin
                    t_reg <= {t_reg[30:0], 1'b0};
                    z_reg <= z_reg + 5'd1;
                end
            end
            OP_LOG:
            begin
                m_reg    <= m2[31] ? m2[31:1] : m2[30:0];
                frac_reg <= {frac_reg[14:0], m2[31]};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            OP_MUL:
            begin
                yi_reg  <= 3'(y_full >> (GAMMA_FRAC_BITS + 16));
                yf_reg  <= 16'(y_full >> GAMMA_FRAC_BITS);
                f_reg   <= 31'd1 << 30;
                cnt_reg <= '0;
                res_reg <= '0;
            end
            OP_EXP:
            begin
                if (yf_reg[15])
                    f_reg <= fprod[60:30];
                yf_reg  <= {yf_reg[14:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
            end
            OP_SCALE:
            begin
                res_reg <= sc_sh[GRAY_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // output register
    logic load_out;
    assign load_out = (cmd.op == OP_EMIT) && stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (load_out)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            gray_value <= res_reg;
            row_end    <= row_end_reg;
        end
    end

endmodule
`default_nettype wire

/* src/binned_display_stretch_gamma_top.sv */
// Top level: 16-bit pixel to 8-bit gray stretch with optional 2x2 binning.
// No-result pixel (binned even row or even column): the sequencer stays idle; a clamped
// result skips the divider. Linear stretch: the restoring divider dominates from transfer to result.
// Gamma stretch: divider, up to 17 normalize shifts, 16 log squarings and 16 exp
// products. One pixel in flight; the output register holds one result.
// Reset: async active low; counters clear, config returns to 640/0/0/65535/4096.
`default_nettype none
module binned_display_stretch_gamma_top #(
    parameter int MAX_WIDTH       = 4096,
    parameter int GAMMA_FRAC_BITS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bdsg_pixel_if.sink                           pixel,
    bdsg_gray_if.source                          display,
    input  wire logic                            cfg_we,
    input  wire logic [bdsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bdsg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bdsg_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    // ready only while the sequencer is idle; a transfer starts one item
    assign pixel.ready = in_ready;

    bdsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath owns config, line buffer and all arithmetic; output register
    // lets the next pixel start while a result waits for its transfer
    bdsg_dp #(
        .MAX_WIDTH       (MAX_WIDTH),
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_value (pixel.pixel_value),
        .frame_start (pixel.frame_start),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (display.valid),
        .out_ready   (display.ready),
        .gray_value  (display.gray_value),
        .row_end     (display.row_end)
    );

endmodule
`default_nettype wire

/* verif/tb_binned_display_stretch_gamma_top.sv */
// Self-checking testbench for the binned display stretch block: directed table, fixed phases, then random phases.
`timescale 1ns / 1ps
`default_nettype none
module tb_binned_display_stretch_gamma_top;
    import bdsg_pkg::*;

    localparam int PERIOD_NS   = 12;
    localparam int CYCLE_LIMIT = 1500000;
    // settle pause, rounded up well beyond the worst gamma result
    localparam int SETTLE      = 200;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              row_end;
    } gray_item_t;

    typedef struct {
        logic [PIX_W-1:0]  pix;
        logic              fs;
        logic              known;
        logic [GRAY_W-1:0] gray;
        logic              row_end;
    } table_row_t;

    typedef struct {
        int   width;
        logic binned;
        int   black;
        int   white;
        int   gamma;
        int   count;
        logic fs_first;
        logic hold;
    } phase_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bdsg_pixel_if pix_if();
    bdsg_gray_if  disp_if();

    binned_display_stretch_gamma_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_if),
        .display   (disp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of configuration and raster state
    int          cfg_width;
    logic        cfg_binned;
    logic [15:0] cfg_black;
    logic [15:0] cfg_white;
    logic [15:0] cfg_gamma;
    int          col_count;
    logic        odd_row;
    logic [15:0] left_hold;
    logic [16:0] pair_line [0:2047];
    logic [63:0] exp_roots [0:15];

    gray_item_t gray_expected[$];
    int errors;
    int snd_idle;
    int rcv_stall;
    int hold_cycles;
    int cycles;

    initial clk = 1'b0;
    always #(PERIOD_NS / 2.0) clk = ~clk;

    function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = res | (64'd1 << b);
            if (cand * cand <= x)
                res = cand;
        end
        return res;
    endfunction

    // s is four times the mean (block sum, or 4*pixel in full mode)
    function automatic logic [7:0] gray_of_sum(input logic [63:0] s);
        longint      n;
        longint      r;
        logic [63:0] t, m, lg, y, yi, yf, f, q;
        logic [15:0] frac;
        int          p;
        if (cfg_gamma == 16'd4096 || cfg_white == cfg_black)
        begin
            if (cfg_white == 0)
                return (s == 0) ? 8'd0 : 8'd255;
            q = (64'd255 * s) / (64'd4 * cfg_white);
            return (q > 255) ? 8'd255 : q[7:0];
        end
        n = longint'(s) - 4 * longint'(cfg_black);
        r = 4 * (longint'(cfg_white) - longint'(cfg_black));
        if (r < 0)
        begin
            n = -n;
            r = -r;
        end
        if (cfg_gamma == 0)
            return 8'd255;
        if (n <= 0)
            return 8'd0;
        if (n >= r)
            return 8'd255;
        t = (64'(n) << 32) / 64'(r);
        if (t == 0)
            return 8'd0;
        p = 31;
        while (t[p] == 1'b0)
            p--;
        m = (p >= 30) ? (t >> (p - 30)) : (t << (30 - p));
        frac = '0;
        // log2 fraction by squaring the Q1.30 mantissa
        for (int j = 15; j >= 0; j--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac[j] = 1'b1;
            end
        end
        lg = (64'(32 - p) << 16) - frac;
        y  = (lg * cfg_gamma) >> 12;
        yi = y >> 16;
        yf = y & 64'hFFFF;
        if (yi >= 8)
            return 8'd0;
        f = 64'd1 << 30;
        for (int j = 0; j < 16; j++)
            if (yf[15 - j])
                f = (f * exp_roots[j]) >> 30;
        q = (64'd255 * f) >> (30 + yi);
        return q[7:0];
    endfunction

    // Advance the raster state for one accepted pixel; returns 1 with a result
    function automatic logic advance_raster(input logic [15:0] px, input logic fs,
                                            output gray_item_t res);
        int          w;
        int          idx;
        logic        last;
        logic [16:0] pair;
        logic        got;
        got = 1'b0;
        res = '0;
        if (fs)
        begin
            col_count = 0;
            odd_row   = 1'b0;
        end
        w = (cfg_width == 0) ? 1 : ((cfg_width > 4096) ? 4096 : cfg_width);
        last = (col_count + 1 >= w);
        if (!cfg_binned)
        begin
            res.gray    = gray_of_sum(64'd4 * px);
            res.row_end = last;
            got = 1'b1;
        end
        else if ((col_count & 1) == 0)
        begin
            if (!last)
                left_hold = px;
        end
        else
        begin
            idx  = col_count >> 1;
            pair = 17'(left_hold) + 17'(px);
            if (idx > 2047)
                idx = 2047;
            if (!odd_row)
                pair_line[idx] = pair;
            else
            begin
                res.gray    = gray_of_sum(64'(pair_line[idx]) + 64'(pair));
                res.row_end = (col_count + 1 >= (w & ~1));
                got = 1'b1;
            end
        end
        if (last)
        begin
            col_count = 0;
            odd_row   = ~odd_row;
        end
        else
            col_count = col_count + 1;
        return got;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        case (idx)
            REG_IMAGE_WIDTH: cfg_width  = value & 16'h1FFF;
            REG_BINNED_MODE: cfg_binned = value[0];
            REG_BLACK_LEVEL: cfg_black  = value[15:0];
            REG_WHITE_LEVEL: cfg_white  = value[15:0];
            REG_GAMMA:       cfg_gamma  = value[15:0];
            default: ;
        endcase
    endtask

    // One pixel transfer; called and returns at a falling edge
    task automatic send_pixel(input logic [15:0] px, input logic fs, input logic known,
                              input logic [7:0] kgray, input logic kre);
        gray_item_t res;
        while ($urandom_range(0, 99) < snd_idle)
        begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= px;
        pix_if.frame_start <= fs;
        do
            @(posedge clk);
        while (!pix_if.ready);
        if (advance_raster(px, fs, res))
        begin
            if (known)
            begin
                res.gray    = kgray;
                res.row_end = kre;
            end
            gray_expected.push_back(res);
        end
        @(negedge clk);
    endtask

    task automatic drain_block();
        pix_if.valid <= 1'b0;
        while (gray_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return cfg_black;
            3: return cfg_white;
            4: return cfg_black + 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic set_idle(input int mode);
        case (mode % 4)
            0: begin snd_idle = 0;  rcv_stall = 0;  end
            1: begin snd_idle = 72; rcv_stall = 0;  end
            2: begin snd_idle = 0;  rcv_stall = 72; end
            default: begin snd_idle = 6; rcv_stall = 6; end
        endcase
    endtask

    task automatic run_phase(input phase_t ph, input int mode);
        logic fs;
        write_reg(REG_IMAGE_WIDTH, ph.width);
        write_reg(REG_BINNED_MODE, ph.binned);
        write_reg(REG_BLACK_LEVEL, ph.black);
        write_reg(REG_WHITE_LEVEL, ph.white);
        write_reg(REG_GAMMA, ph.gamma);
        cfg_we <= 1'b0;
        set_idle(mode);
        if (ph.hold)
            hold_cycles = LONG_HOLD;
        for (int i = 0; i < ph.count; i++)
        begin
            fs = (i == 0) ? ph.fs_first : ($urandom_range(0, 63) == 0);
            send_pixel(pick_pixel(), fs, 1'b0, 8'd0, 1'b0);
        end
        drain_block();
    endtask

    // Receiver: random stalls, plus long hold-offs counted down here
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            disp_if.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            disp_if.ready <= ($urandom_range(0, 99) >= rcv_stall);
    end

    // Result checker
    always @(posedge clk)
    begin
        gray_item_t want;
        if (rst_n && disp_if.valid && disp_if.ready)
        begin
            if (gray_expected.size() == 0)
                report_mismatch("unexpected result, gray", disp_if.gray_value, -1);
            else
            begin
                want = gray_expected.pop_front();
                if (disp_if.gray_value !== want.gray)
                    report_mismatch("gray_value", disp_if.gray_value, want.gray);
                if (disp_if.row_end !== want.row_end)
                    report_mismatch("row_end", disp_if.row_end, want.row_end);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_binned_display_stretch_gamma_top: FAIL");
            $finish;
        end
    end

    table_row_t dir_rows [] = '{
        '{16'd0,     1'b1, 1'b1, 8'd0,   1'b0},
        '{16'hFFFF,  1'b0, 1'b1, 8'd255, 1'b0},
        '{16'd1,     1'b0, 1'b1, 8'd0,   1'b0},
        '{16'h8000,  1'b0, 1'b1, 8'd127, 1'b0},
        '{16'hAAAA,  1'b0, 1'b0, 8'd0,   1'b0},
        '{16'h5555,  1'b0, 1'b0, 8'd0,   1'b0},
        '{16'h00FF,  1'b0, 1'b0, 8'd0,   1'b0},
        '{16'hFF00,  1'b0, 1'b0, 8'd0,   1'b0}
    };

    phase_t fixed_phases [] = '{
        // width lowered mid row: 5 pixels at width 8, then width 3 without a frame start
        '{8,    1'b0, 0,     65535, 4096,  5,  1'b1, 1'b0},
        '{3,    1'b0, 0,     65535, 4096,  12, 1'b0, 1'b0},
        // zero width acts as one: binned mode never completes a block
        '{0,    1'b1, 0,     65535, 4096,  20, 1'b1, 1'b0},
        '{8191, 1'b0, 1000,  60000, 2048,  60, 1'b1, 1'b0},
        // odd last column and row dropped
        '{5,    1'b1, 0,     65535, 4096,  80, 1'b1, 1'b0},
        '{4,    1'b1, 100,   50000, 0,     30, 1'b1, 1'b0},
        // binned to full mid frame
        '{4,    1'b0, 100,   50000, 0,     10, 1'b0, 1'b0},
        '{6,    1'b0, 0,     0,     4096,  60, 1'b1, 1'b0},
        '{7,    1'b1, 65535, 0,     65535, 80, 1'b1, 1'b0},
        '{6,    1'b1, 0,     65535, 1,     80, 1'b1, 1'b1},
        '{2,    1'b0, 20000, 20000, 8192,  40, 1'b1, 1'b0},
        '{4096, 1'b0, 4096,  8192,  16384, 40, 1'b1, 1'b0}
    };

    initial
    begin
        phase_t ph;
        cycles             = 0;
        errors             = 0;
        hold_cycles        = 0;
        snd_idle           = 0;
        rcv_stall          = 0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_value = '0;
        pix_if.frame_start = 1'b0;
        disp_if.ready      = 1'b0;
        cfg_width  = 640;
        cfg_binned = 1'b0;
        cfg_black  = 16'd0;
        cfg_white  = 16'hFFFF;
        cfg_gamma  = 16'd4096;
        col_count  = 0;
        odd_row    = 1'b0;
        left_hold  = '0;
        exp_roots[0] = 64'd1 << 29;
        for (int k = 1; k < 16; k++)
            exp_roots[k] = sqrt_floor(exp_roots[k - 1] << 30);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows under the reset configuration
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].pix, dir_rows[i].fs, dir_rows[i].known,
                       dir_rows[i].gray, dir_rows[i].row_end);
        drain_block();

        foreach (fixed_phases[i])
            run_phase(fixed_phases[i], i);

        for (int i = 0; i < 8; i++)
        begin
            ph.width    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8191)
                                                      : $urandom_range(1, 12);
            ph.binned   = $urandom_range(0, 1);
            ph.black    = $urandom_range(0, 65535);
            ph.white    = $urandom_range(0, 65535);
            ph.gamma    = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(1, 65535);
            ph.count    = 90;
            ph.fs_first = 1'b1;
            ph.hold     = (i == 5);
            run_phase(ph, i);
        end

        if (errors == 0)
            $display("tb_binned_display_stretch_gamma_top: PASS");
        else
            $display("tb_binned_display_stretch_gamma_top: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
